@@ src/sha512_pkg.sv @@
// sha-512 engine shared types, constants and round functions
package sha512_pkg;

	localparam int WORD_W  = 64;
	localparam int ROUNDS  = 80;
	localparam int BLK_BYTES = 128;
	localparam int FILL_W  = $clog2(BLK_BYTES);
	localparam int RND_W   = $clog2(ROUNDS);

	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_ABSORB = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [FILL_W-1:0] PAD_LEN_POS = FILL_W'(112);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLK_BYTES - 1);
	localparam logic [RND_W-1:0] ROUND_LAST = RND_W'(ROUNDS - 1);

	typedef logic [7:0][WORD_W-1:0] hash_t;

	localparam hash_t IV = {
		64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
		64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
		64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
		64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
	};

	typedef struct packed {
		logic             push;
		logic [7:0]       byte_in;
		logic             step;
		logic [RND_W-1:0] idx;
	} sched_ctrl_t;

	typedef struct packed {
		logic iv_load;
		logic start;
		logic round;
		logic fold;
	} round_ctrl_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] big_sig0(input logic [63:0] x);
		big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] big_sig1(input logic [63:0] x);
		big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [63:0] sml_sig0(input logic [63:0] x);
		sml_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] sml_sig1(input logic [63:0] x);
		sml_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [63:0] round_k(input logic [RND_W-1:0] t);
		logic [63:0] k;
		unique case (t)
			7'd0:  k = 64'h428a2f98d728ae22;
			7'd1:  k = 64'h7137449123ef65cd;
			7'd2:  k = 64'hb5c0fbcfec4d3b2f;
			7'd3:  k = 64'he9b5dba58189dbbc;
			7'd4:  k = 64'h3956c25bf348b538;
			7'd5:  k = 64'h59f111f1b605d019;
			7'd6:  k = 64'h923f82a4af194f9b;
			7'd7:  k = 64'hab1c5ed5da6d8118;
			7'd8:  k = 64'hd807aa98a3030242;
			7'd9:  k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c;
			7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f;
			7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235;
			7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2;
			7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5;
			7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275;
			7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4;
			7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab;
			7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f;
			7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2;
			7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f;
			7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc;
			7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed;
			7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de;
			7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6;
			7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364;
			7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791;
			7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218;
			7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a;
			7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8;
			7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99;
			7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63;
			7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373;
			7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc;
			7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72;
			7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28;
			7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915;
			7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c;
			7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e;
			7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba;
			7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae;
			7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84;
			7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc;
			7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6;
			7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec;
			7'd79: k = 64'h6c44198c4a475817;
			default: k = '0;
		endcase
		round_k = k;
	endfunction

endpackage

@@ src/sha512_sched.sv @@
// block buffer and message schedule window, produces k+w for the next round
module sha512_sched
	import sha512_pkg::*;
(
	input  logic        clk,
	input  sched_ctrl_t ctrl,
	output logic [63:0] kw
);

	// win_q[0] is the oldest word; bytes shift in at the low end of win_q[15]
	logic [15:0][63:0] win_q;
	logic [63:0]       kw_q;
	logic [63:0]       w_new;

	always_comb begin
		if (ctrl.idx < RND_W'(16)) begin
			w_new = win_q[0];
		end else begin
			w_new = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][55:0], win_q[i+1][63:56]};
			end
			win_q[15] <= {win_q[15][55:0], ctrl.byte_in};
		end else if (ctrl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
			kw_q <= round_k(ctrl.idx) + w_new;
		end
	end

	assign kw = kw_q;

endmodule

@@ src/sha512_round.sv @@
// hash words and working variables with the shared round unit
module sha512_round
	import sha512_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  round_ctrl_t ctrl,
	input  logic [63:0] kw,
	output hash_t       hash
);

	hash_t       hash_q;
	hash_t       v_q;
	logic [63:0] t1;
	logic [63:0] t2;

	always_comb begin
		t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + kw;
		t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= IV;
		end else if (ctrl.iv_load) begin
			hash_q <= IV;
		end else if (ctrl.fold) begin
			for (int k = 0; k < 8; k++) begin
				hash_q[k] <= hash_q[k] + v_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= hash_q;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign hash = hash_q;

endmodule

@@ src/sha512_stream_hash_core.sv @@
// sha-512 stream hash core top level: sequencer, padding, digest output
//
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+-------------------------------------
// in       | in_valid  | in_ready  | op, data_byte
// out      | out_valid | out_ready | digest_word, word_index, last_word
//
// begin and absorb are each taken in a single beat; absorbing the 128th byte of a
// block starts a compression (schedule prime, 80 rounds, fold) in the single
// round unit. finish pushes 17 to 144 padding and length bytes at one per
// cycle, compressing each full block, then sends eight beats.
// in_ready is low from finish until the last digest beat is taken, and
// during a compression. reset loads the initial hash words and clears counts.
module sha512_stream_hash_core
	import sha512_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       bytecnt_q;
	logic [63:0]       bits_q;
	logic [RND_W-1:0]  round_q;
	logic              pad_q;
	logic              pad_first_q;
	logic              crossed_q;
	logic              done_q;
	logic              out_valid_q;
	logic [2:0]        word_idx_q;
	logic [63:0]       digest_q;

	sched_ctrl_t sched_ctrl;
	round_ctrl_t round_ctrl;
	logic [63:0] kw;
	hash_t       hash;
	logic        in_fire;
	logic        len_phase;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// length bytes fill the last eight slots of the final block
	assign len_phase = crossed_q && !pad_first_q && (fill_q[FILL_W-1:3] == '1);
	assign len_byte  = 8'(bits_q >> {~fill_q[2:0], 3'b000});
	assign pad_byte  = pad_first_q ? PAD_MARK : (len_phase ? len_byte : 8'h00);

	always_comb begin
		sched_ctrl = '0;
		round_ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				sched_ctrl.push    = in_fire && (op == OP_ABSORB);
				sched_ctrl.byte_in = data_byte;
				round_ctrl.iv_load = in_fire && (op == OP_BEGIN);
			end
			ST_PAD: begin
				sched_ctrl.push    = 1'b1;
				sched_ctrl.byte_in = pad_byte;
			end
			ST_PREP: begin
				sched_ctrl.step  = 1'b1;
				sched_ctrl.idx   = '0;
				round_ctrl.start = 1'b1;
			end
			ST_ROUND: begin
				sched_ctrl.step  = (round_q != ROUND_LAST);
				sched_ctrl.idx   = round_q + RND_W'(1);
				round_ctrl.round = 1'b1;
			end
			ST_FOLD: begin
				round_ctrl.fold = 1'b1;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bytecnt_q   <= '0;
			round_q     <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			crossed_q   <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			word_idx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (op)
							OP_BEGIN: begin
								fill_q    <= '0;
								bytecnt_q <= '0;
							end
							OP_ABSORB: begin
								bytecnt_q <= bytecnt_q + 64'd1;
								fill_q    <= fill_q + FILL_W'(1);
								if (fill_q == FILL_LAST) begin
									state_q <= ST_PREP;
								end
							end
							OP_FINISH: begin
								bits_q      <= {bytecnt_q[60:0], 3'b000};
								crossed_q   <= (fill_q < PAD_LEN_POS);
								pad_first_q <= 1'b1;
								pad_q       <= 1'b1;
								state_q     <= ST_PAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PAD: begin
					bytecnt_q   <= bytecnt_q + 64'd1;
					fill_q      <= fill_q + FILL_W'(1);
					pad_first_q <= 1'b0;
					if (fill_q == FILL_LAST) begin
						crossed_q <= 1'b1;
						done_q    <= len_phase;
						state_q   <= ST_PREP;
					end
				end
				ST_PREP: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + RND_W'(1);
					if (round_q == ROUND_LAST) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (done_q) begin
						word_idx_q <= '0;
						state_q    <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					// first cycle loads word 0, then each taken beat loads the next
					if (!out_valid_q) begin
						digest_q    <= hash[word_idx_q];
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						if (word_idx_q == 3'd7) begin
							out_valid_q <= 1'b0;
							pad_q       <= 1'b0;
							done_q      <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							word_idx_q <= word_idx_q + 3'd1;
							digest_q   <= hash[word_idx_q + 3'd1];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sha512_sched u_sched (
		.clk  (clk),
		.ctrl (sched_ctrl),
		.kw   (kw)
	);

	sha512_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (round_ctrl),
		.kw     (kw),
		.hash   (hash)
	);

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = word_idx_q;
	assign last_word   = (word_idx_q == 3'd7);

endmodule

@@ sim/sha512_digest_checker.sv @@
// digest checker for the sha-512 stream core: predicts each digest beat and compares it
module sha512_digest_checker
	import sha512_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          mismatches,
	output int          words_due,
	output int          words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 40;

	localparam logic [0:7][63:0] H0 = {
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [0:79][63:0] KR = {
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	typedef struct {
		logic [63:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	digest_beat_t digest_q[$];

	logic [63:0] chain [8];
	logic [7:0]  blk [128];
	logic [6:0]  fill;
	logic [63:0] msg_bytes;
	int          errs;
	int          checked;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic void fold_block();
		logic [63:0] w [80];
		logic [63:0] v [8];
		logic [63:0] t1;
		logic [63:0] t2;
		for (int t = 0; t < 16; t++) begin
			w[t] = '0;
			for (int k = 0; k < 8; k++)
				w[t] = {w[t][55:0], blk[8 * t + k]};
		end
		for (int t = 16; t < 80; t++)
			w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
				+ (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
		for (int k = 0; k < 8; k++)
			v[k] = chain[k];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[t] + w[t];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			chain[k] = chain[k] + v[k];
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		blk[fill] = b;
		fill = fill + 7'd1;
		if (fill == '0) fold_block();
	endfunction

	function automatic void take_beat(input logic [1:0] code, input logic [7:0] b);
		logic [63:0] bits;
		int pad;
		case (code)
			OP_BEGIN: begin
				for (int k = 0; k < 8; k++)
					chain[k] = H0[k];
				fill = '0;
				msg_bytes = '0;
			end
			OP_ABSORB: begin
				msg_bytes = msg_bytes + 64'd1;
				push_byte(b);
			end
			OP_FINISH: begin
				bits = msg_bytes << 3;
				// length field must start at byte 112, spill into a second block if past it
				pad = (fill < 7'd112) ? 112 - int'(fill) : 240 - int'(fill);
				push_byte(PAD_MARK);
				repeat (pad + 7) push_byte(8'h00);
				for (int i = 0; i < 8; i++)
					push_byte(bits[63 - 8 * i -: 8]);
				msg_bytes = msg_bytes + 64'(pad + 16);
				for (int i = 0; i < 8; i++)
					digest_q.push_back('{chain[i], 3'(i), i == 7});
			end
			default: ;
		endcase
	endfunction

	function automatic void note_miss(input string what, input logic [63:0] want,
		input logic [63:0] got);
		errs++;
		if (errs <= MAX_REPORTS)
			$display("%0t ns: %s expected %h got %h", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		digest_beat_t want;
		if (!arst_n) begin
			for (int k = 0; k < 8; k++)
				chain[k] = H0[k];
			fill = '0;
			msg_bytes = '0;
			digest_q.delete();
		end else begin
			// output side first: a finish never yields a beat on the edge it is taken
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					note_miss("unrequested digest beat, word", 64'd0, digest_word);
				end else begin
					want = digest_q.pop_front();
					checked++;
					if (digest_word !== want.word)
						note_miss($sformatf("digest word %0d", want.idx), want.word, digest_word);
					if (word_index !== want.idx)
						note_miss("word_index", 64'(want.idx), 64'(word_index));
					if (last_word !== want.last)
						note_miss($sformatf("last_word on word %0d", want.idx), 64'(want.last),
							64'(last_word));
				end
			end
			if (in_valid && in_ready) take_beat(op, data_byte);
		end
		mismatches <= errs;
		words_due <= digest_q.size();
		words_checked <= checked;
	end

endmodule

@@ sim/tb_sha512_stream_hash_core.sv @@
// testbench top for the sha-512 stream hash core: stimulus, receiver stalls and verdict
module tb_sha512_stream_hash_core;
	timeunit 1ns;
	timeprecision 1ps;
	import sha512_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_BEGIN;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int mismatches;
	int words_due;
	int words_checked;

	bit in_gaps = 1'b1;
	bit out_gaps = 1'b1;
	bit strays = 1'b1;
	bit hold_req = 1'b0;
	int beats_sent = 0;
	int longest = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sha512_stream_hash_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	sha512_digest_checker digest_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.mismatches    (mismatches),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	// valid stays up across back-to-back beats; it only drops for a gap
	task automatic send_beat(input logic [1:0] code, input logic [7:0] b);
		if (in_gaps) begin
			while ($urandom_range(99) < 14) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		op <= code;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_message(input int len, input bit fresh);
		if (len > longest) longest = len;
		if (fresh) send_beat(OP_BEGIN, 8'($urandom_range(255)));
		repeat (len) begin
			if ($urandom_range(19) == 0) send_beat(OP_UNUSED, 8'($urandom_range(255)));
			// a stray begin throws away the message so far
			if (strays && $urandom_range(49) == 0) send_beat(OP_BEGIN, 8'($urandom_range(255)));
			send_beat(OP_ABSORB, 8'($urandom_range(255)));
		end
		send_beat(OP_FINISH, 8'($urandom_range(255)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gaps) begin
				out_ready <= ($urandom_range(99) >= 14);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no beat moved for %0d cycles, %0d digest words still due", QUIET_LIMIT,
			words_due);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight out of reset, no begin: works on the initial hash words
		send_beat(OP_UNUSED, 8'hff);
		send_beat(OP_ABSORB, 8'h00);
		send_beat(OP_ABSORB, 8'hff);
		send_beat(OP_FINISH, 8'h00);
		// keep going after a finish without a new begin
		send_beat(OP_ABSORB, 8'ha5);
		send_beat(OP_FINISH, 8'hff);
		drain();
		// empty message
		send_beat(OP_BEGIN, 8'hff);
		send_beat(OP_FINISH, 8'h5a);
		// "abc" with an unused code in the middle
		send_beat(OP_BEGIN, 8'h00);
		send_beat(OP_ABSORB, 8'h61);
		send_beat(OP_UNUSED, 8'h00);
		send_beat(OP_ABSORB, 8'h62);
		send_beat(OP_ABSORB, 8'h63);
		send_beat(OP_FINISH, 8'h00);
		// restart mid-message
		send_beat(OP_BEGIN, 8'h00);
		send_beat(OP_ABSORB, 8'h80);
		send_beat(OP_BEGIN, 8'h00);
		send_beat(OP_ABSORB, 8'h01);
		send_beat(OP_FINISH, 8'h00);

		while (beats_sent < 30)
			send_message(($urandom_range(3) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12),
				$urandom_range(7) != 0);
		drain();

		// full-rate stretch: a message long enough that padding spills into a second block
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		strays = 1'b0;
		send_message($urandom_range(112, 116), 1'b1);
		strays = 1'b1;
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		drain();

		// receiver holds off while the sender keeps offering beats
		hold_req = 1'b1;
		send_message(3, 1'b1);
		send_message($urandom_range(0, 6), 1'b1);
		send_message($urandom_range(0, 6), 1'b0);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d input beats and %0d digests, longest message %0d bytes",
			beats_sent, words_checked / 8, longest);
		$display("incl. unused codes, finish without begin, two-block padding, output hold-off");
		if (mismatches == 0 && words_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
